// ===== sv/wsd_pkg.sv =====
package wsd_pkg;

  localparam int LENGTH_BITS_DEF = 32;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [3:0] OP_CLOSE  = 4'd8;
  localparam logic [3:0] OP_PING   = 4'd9;
  localparam logic [3:0] OP_DATA_MAX = 4'd2;
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT,
    PH_KEY,
    PH_DATA,
    PH_CLOSED
  } phase_t;

  typedef enum logic [2:0] {
    KIND_MSG    = 3'd0,
    KIND_PING   = 3'd1,
    KIND_REASON = 3'd2,
    KIND_CODE   = 3'd3,
    KIND_END    = 3'd4
  } kind_t;

  // one queued result, still masked; the back end unmasks and formats it
  typedef struct packed {
    logic [7:0] rx;
    logic [7:0] key;
    kind_t      kind;
    logic [7:0] close_hi;
    logic       msg_end;
    logic       len_err;
  } wsd_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } wsd_q_status_t;

endpackage

// ===== sv/wsd_front.sv =====
module wsd_front
  import wsd_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      acc,
  input  logic [7:0] rx,
  output logic      push,
  output wsd_item_t item,
  output logic      closed
);

  phase_t                 phase_r, phase_nxt;
  logic                   fin_r, fin_nxt;
  logic [3:0]             op_r, op_nxt;
  logic                   mask_r, mask_nxt;
  logic [2:0]             cnt_r, cnt_nxt;
  logic [LENGTH_BITS-1:0] rem_r, rem_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [31:0]            key_r, key_nxt;
  logic [1:0]             pidx_r, pidx_nxt;
  logic [7:0]             hi_r, hi_nxt;
  logic [1:0]             cseen_r, cseen_nxt;

  logic [7:0]             key_b;
  logic [7:0]             b;
  logic                   is_data;
  logic                   last;
  logic [LENGTH_BITS-1:0] rem_dec;
  logic [LENGTH_BITS-1:0] rem_shift;
  logic                   ovf_shift;
  logic                   ld_go;
  logic                   ld_mask;
  logic                   ld_ovf;
  logic [LENGTH_BITS-1:0] ld_rem;
  logic                   fb_go;
  logic [LENGTH_BITS-1:0] fb_rem;

  always_comb begin
    case (pidx_r)
      2'd0:    key_b = key_r[31:24];
      2'd1:    key_b = key_r[23:16];
      2'd2:    key_b = key_r[15:8];
      default: key_b = key_r[7:0];
    endcase
    if (!mask_r) key_b = 8'h00;
  end

  assign b         = rx ^ key_b;
  assign is_data   = (op_r <= OP_DATA_MAX);
  assign rem_dec   = rem_r - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
  assign last      = (rem_dec == '0);
  assign rem_shift = {rem_r[LENGTH_BITS-9:0], rx};
  // any bits pushed out of the top mean the frame length does not fit
  assign ovf_shift = ovf_r | (|rem_r[LENGTH_BITS-1 -: 8]);
  assign closed    = (phase_r == PH_CLOSED);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR0;
      fin_r   <= 1'b0;
      op_r    <= '0;
      mask_r  <= 1'b0;
      cnt_r   <= '0;
      rem_r   <= '0;
      ovf_r   <= 1'b0;
      key_r   <= '0;
      pidx_r  <= '0;
      hi_r    <= '0;
      cseen_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      fin_r   <= fin_nxt;
      op_r    <= op_nxt;
      mask_r  <= mask_nxt;
      cnt_r   <= cnt_nxt;
      rem_r   <= rem_nxt;
      ovf_r   <= ovf_nxt;
      key_r   <= key_nxt;
      pidx_r  <= pidx_nxt;
      hi_r    <= hi_nxt;
      cseen_r <= cseen_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    fin_nxt   = fin_r;
    op_nxt    = op_r;
    mask_nxt  = mask_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    ovf_nxt   = ovf_r;
    key_nxt   = key_r;
    pidx_nxt  = pidx_r;
    hi_nxt    = hi_r;
    cseen_nxt = cseen_r;

    ld_go   = 1'b0;
    ld_mask = mask_r;
    ld_ovf  = ovf_shift;
    ld_rem  = rem_shift;
    fb_go   = 1'b0;
    fb_rem  = rem_r;

    push          = 1'b0;
    item.rx       = rx;
    item.key      = key_b;
    item.kind     = KIND_END;
    item.close_hi = hi_r;
    item.msg_end  = 1'b0;
    item.len_err  = 1'b0;

    if (acc) begin
      case (phase_r)
        PH_HDR0: begin
          fin_nxt   = rx[7];
          op_nxt    = rx[3:0];
          key_nxt   = '0;
          phase_nxt = PH_HDR1;
        end
        PH_HDR1: begin
          mask_nxt = rx[7];
          ovf_nxt  = 1'b0;
          rem_nxt  = '0;
          if (rx[6:0] == LEN_EXT16) begin
            cnt_nxt   = 3'd1;
            phase_nxt = PH_EXT;
          end else if (rx[6:0] == LEN_EXT64) begin
            cnt_nxt   = 3'd7;
            phase_nxt = PH_EXT;
          end else begin
            rem_nxt = {{(LENGTH_BITS-7){1'b0}}, rx[6:0]};
            ld_go   = 1'b1;
            ld_mask = rx[7];
            ld_ovf  = 1'b0;
            ld_rem  = {{(LENGTH_BITS-7){1'b0}}, rx[6:0]};
          end
        end
        PH_EXT: begin
          rem_nxt = rem_shift;
          ovf_nxt = ovf_shift;
          if (cnt_r == '0) ld_go = 1'b1;
          else cnt_nxt = cnt_r - 3'd1;
        end
        PH_KEY: begin
          key_nxt = {key_r[23:0], rx};
          if (cnt_r == '0) fb_go = 1'b1;
          else cnt_nxt = cnt_r - 3'd1;
        end
        PH_DATA: begin
          pidx_nxt = pidx_r + 2'd1;
          rem_nxt  = rem_dec;
          if (last) phase_nxt = PH_HDR0;
          if (is_data) begin
            push         = 1'b1;
            item.kind    = KIND_MSG;
            item.msg_end = last & fin_r;
          end else if (op_r == OP_PING) begin
            push      = 1'b1;
            item.kind = KIND_PING;
          end else if (op_r == OP_CLOSE) begin
            if (cseen_r == 2'd0) begin
              hi_nxt    = b;
              cseen_nxt = 2'd1;
              // close with a single byte: no code, just the end
              if (last) begin
                phase_nxt    = PH_CLOSED;
                push         = 1'b1;
                item.kind    = KIND_END;
                item.msg_end = 1'b1;
              end
            end else begin
              if (last) phase_nxt = PH_CLOSED;
              push         = 1'b1;
              item.msg_end = last;
              if (cseen_r == 2'd1) begin
                cseen_nxt = 2'd2;
                item.kind = KIND_CODE;
              end else begin
                item.kind = KIND_REASON;
              end
            end
          end
        end
        default: ;
      endcase
    end

    if (ld_go) begin
      if (ld_ovf) begin
        phase_nxt    = PH_CLOSED;
        push         = 1'b1;
        item.kind    = KIND_END;
        item.msg_end = 1'b1;
        item.len_err = 1'b1;
      end else if (ld_mask) begin
        cnt_nxt   = 3'd3;
        phase_nxt = PH_KEY;
      end else begin
        fb_go  = 1'b1;
        fb_rem = ld_rem;
      end
    end

    if (fb_go) begin
      pidx_nxt  = '0;
      cseen_nxt = '0;
      if (fb_rem != '0) begin
        phase_nxt = PH_DATA;
      end else if (op_r == OP_CLOSE) begin
        phase_nxt    = PH_CLOSED;
        push         = 1'b1;
        item.kind    = KIND_END;
        item.msg_end = 1'b1;
      end else begin
        phase_nxt = PH_HDR0;
        if (is_data && fin_r) begin
          push         = 1'b1;
          item.kind    = KIND_END;
          item.msg_end = 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/wsd_queue.sv =====
module wsd_queue
  import wsd_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  wsd_item_t     push_item,
  input  logic          pop,
  output wsd_item_t     pop_item,
  output wsd_q_status_t status
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

  wsd_item_t     mem [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push;
  logic          do_pop;

  assign status.full  = (cnt_r == CNT_FULL);
  assign status.empty = (cnt_r == '0);
  assign do_push      = push & ~status.full;
  assign do_pop       = pop & ~status.empty;
  assign pop_item     = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_item;
  end

endmodule

// ===== sv/wsd_back.sv =====
module wsd_back
  import wsd_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  wsd_item_t     item,
  input  wsd_q_status_t q_status,
  output logic          pop,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [23:0]   out_tdata,
  output logic [3:0]    out_tuser,
  output logic          out_tlast
);

  logic        valid_r, valid_nxt;
  logic [23:0] data_r, data_nxt;
  logic [3:0]  user_r, user_nxt;
  logic        last_r, last_nxt;
  logic [7:0]  b;
  logic        load;

  assign b    = item.rx ^ item.key;
  assign load = ~q_status.empty & (~valid_r | out_tready);
  assign pop  = load;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    user_nxt  = user_r;
    last_nxt  = last_r;
    if (load) begin
      valid_nxt = 1'b1;
      user_nxt  = {item.len_err, item.kind};
      last_nxt  = item.msg_end;
      case (item.kind)
        KIND_MSG, KIND_PING, KIND_REASON: data_nxt = {16'h0000, b};
        KIND_CODE:                        data_nxt = {item.close_hi, b, 8'h00};
        default:                          data_nxt = '0;
      endcase
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    user_r <= user_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;
  assign out_tlast  = last_r;

endmodule

// ===== sv/websocket_frame_deframer.sv =====
// channel | dir | tdata                             | tuser                     | tlast
// in_     | in  | [7:0] rx_byte                     | -                         | -
// out_    | out | [7:0] payload_byte [23:8] close_code | [2:0] kind [3] length_error | message_end
//
// One byte per cycle while the result queue has room; header and unmask logic is combinational.
// Each result is written to the queue at the byte's accepting edge, then loaded into the
// output register that drives out_tvalid when that register is empty or being drained.
// rst_n is synchronous; after reset the parser waits for the first header byte.
// in_tready drops only when the result queue is full; out stalls fill the queue.
// After a close or a length error every byte is still taken and dropped.
module websocket_frame_deframer
  import wsd_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] payload_byte, [23:8] close_code
  output logic [3:0]  out_tuser,  // [2:0] kind, [3] length_error
  output logic        out_tlast
);

  logic          acc;
  logic          push;
  logic          pop;
  logic          closed;
  wsd_item_t     push_item;
  wsd_item_t     pop_item;
  wsd_q_status_t q_status;

  assign in_tready = ~q_status.full;
  assign acc       = in_tvalid & in_tready;

  wsd_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .acc    (acc),
    .rx     (in_tdata),
    .push   (push),
    .item   (push_item),
    .closed (closed)
  );

  wsd_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .status    (q_status)
  );

  wsd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (pop_item),
    .q_status   (q_status),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

`ifndef NO_ASSERTIONS
  a_closed_silent: assert property (@(posedge clk) disable iff (!rst_n)
    closed |-> !push)
    else $error("result queued after link closed");

  a_err_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[3] |-> out_tlast && out_tuser[2:0] == KIND_END)
    else $error("length error without end marker");

  a_code_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2:0] == KIND_CODE |-> out_tdata[7:0] == 8'h00)
    else $error("close code result carries a payload byte");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> acc && !q_status.full)
    else $error("queue push without an accepted byte");
`endif

endmodule

// ===== verif/testbench.sv =====
module testbench;
  import wsd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam logic [3:0] OP_PONG = 4'hA;
  localparam logic [63:0] LEN_MAX = (64'd1 << LENGTH_BITS_DEF) - 64'd1;
  localparam int N_DIR = 27;

  typedef struct packed {
    logic [7:0]  data;
    kind_t       kind;
    logic [15:0] code;
    logic        last;
    logic        err;
  } deframe_res_t;

  typedef struct packed {
    logic [7:0]   rx;
    logic         typed;
    deframe_res_t res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [3:0]  out_tuser;
  logic        out_tlast;

  websocket_frame_deframer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #5 clk = ~clk;

  // parser state mirrored from the byte stream
  phase_t      ph = PH_HDR0;
  logic        fr_fin = 1'b0;
  logic [3:0]  fr_op = 4'd0;
  logic        fr_masked = 1'b0;
  logic [2:0]  fld_left = 3'd0;
  logic [63:0] len_left = 64'd0;
  logic [31:0] key_word = 32'd0;
  logic [1:0]  pay_idx = 2'd0;
  logic [7:0]  code_hi = 8'd0;
  logic [1:0]  code_cnt = 2'd0;

  deframe_res_t due_results [$];
  deframe_res_t want;
  int bytes_taken = 0;
  int results_seen = 0;
  int frames_sent = 0;
  int mismatches = 0;
  int cycle_cnt = 0;
  logic quiet = 1'b0;
  logic hold_out = 1'b0;
  string end_how = "none";

  function automatic bit payload_start(output deframe_res_t r);
    r = '0;
    pay_idx = 2'd0;
    code_cnt = 2'd0;
    if (len_left != 64'd0) begin
      ph = PH_DATA;
      return 1'b0;
    end
    ph = PH_HDR0;
    if (fr_op == OP_CLOSE) begin
      ph = PH_CLOSED;
      r.kind = KIND_END;
      r.last = 1'b1;
      return 1'b1;
    end
    if (fr_op <= OP_DATA_MAX && fr_fin) begin
      r.kind = KIND_END;
      r.last = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit length_complete(output deframe_res_t r);
    r = '0;
    if (len_left > LEN_MAX) begin
      ph = PH_CLOSED;
      r.kind = KIND_END;
      r.last = 1'b1;
      r.err = 1'b1;
      return 1'b1;
    end
    if (fr_masked) begin
      fld_left = 3'd3;
      ph = PH_KEY;
      return 1'b0;
    end
    return payload_start(r);
  endfunction

  function automatic bit deframe_byte(input logic [7:0] rx, output deframe_res_t r);
    logic [7:0] k;
    logic [7:0] b;
    logic fin_end;
    r = '0;
    case (ph)
      PH_HDR0: begin
        fr_fin = rx[7];
        fr_op = rx[3:0];
        key_word = 32'd0;
        ph = PH_HDR1;
        return 1'b0;
      end
      PH_HDR1: begin
        fr_masked = rx[7];
        len_left = 64'd0;
        if (rx[6:0] == LEN_EXT16) begin
          fld_left = 3'd1;
          ph = PH_EXT;
          return 1'b0;
        end
        if (rx[6:0] == LEN_EXT64) begin
          fld_left = 3'd7;
          ph = PH_EXT;
          return 1'b0;
        end
        len_left = {57'd0, rx[6:0]};
        return length_complete(r);
      end
      PH_EXT: begin
        len_left = {len_left[55:0], rx};
        if (fld_left == 3'd0) return length_complete(r);
        fld_left--;
        return 1'b0;
      end
      PH_KEY: begin
        key_word = {key_word[23:0], rx};
        if (fld_left == 3'd0) return payload_start(r);
        fld_left--;
        return 1'b0;
      end
      PH_DATA: begin
        // first key byte received masks payload byte 0
        k = fr_masked ? key_word[8 * (3 - int'(pay_idx)) +: 8] : 8'h00;
        b = rx ^ k;
        pay_idx++;
        len_left--;
        fin_end = (len_left == 64'd0);
        if (fin_end) ph = PH_HDR0;
        if (fr_op <= OP_DATA_MAX) begin
          r.data = b;
          r.kind = KIND_MSG;
          r.last = fin_end && fr_fin;
          return 1'b1;
        end
        if (fr_op == OP_PING) begin
          r.data = b;
          r.kind = KIND_PING;
          return 1'b1;
        end
        if (fr_op != OP_CLOSE) return 1'b0;
        if (code_cnt == 2'd0) begin
          code_hi = b;
          code_cnt = 2'd1;
          if (fin_end) begin
            // close with a lone byte: no code, just the end
            ph = PH_CLOSED;
            r.kind = KIND_END;
            r.last = 1'b1;
            return 1'b1;
          end
          return 1'b0;
        end
        if (fin_end) ph = PH_CLOSED;
        r.last = fin_end;
        if (code_cnt == 2'd1) begin
          code_cnt = 2'd2;
          r.kind = KIND_CODE;
          r.code = {code_hi, b};
          return 1'b1;
        end
        r.data = b;
        r.kind = KIND_REASON;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit typed, input deframe_res_t fixed);
    int gap;
    deframe_res_t got;
    bit has;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    has = deframe_byte(b, got);
    if (typed) due_results.push_back(fixed);
    else if (has) due_results.push_back(got);
    bytes_taken++;
    quiet <= (bytes_taken >= 450 && bytes_taken < 550);
  endtask

  // enc: 0 seven-bit length, 1 16-bit extended, 2 64-bit extended
  task automatic send_frame(input logic [3:0] op, input logic fin, input logic [63:0] len,
                            input logic masked, input int enc);
    logic [6:0] len7;
    logic [2:0] rsv;
    rsv = 3'($urandom);
    len7 = (enc == 1) ? LEN_EXT16 : (enc == 2) ? LEN_EXT64 : len[6:0];
    send_byte({fin, rsv, op}, 1'b0, '0);
    send_byte({masked, len7}, 1'b0, '0);
    if (enc == 1) for (int i = 1; i >= 0; i--) send_byte(len[8*i +: 8], 1'b0, '0);
    if (enc == 2) for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8], 1'b0, '0);
    frames_sent++;
    if (len > LEN_MAX) return;
    if (masked) repeat (4) send_byte(8'($urandom), 1'b0, '0);
    for (longint n = 0; n < longint'(len); n++) send_byte(8'($urandom), 1'b0, '0);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: data %h kind %0d code %h end %b err %b",
                   out_tdata[7:0], out_tuser[2:0], out_tdata[23:8], out_tlast, out_tuser[3]);
      end else begin
        want = due_results.pop_front();
        if (out_tdata[7:0] != want.data || out_tuser[2:0] != want.kind ||
            out_tdata[23:8] != want.code || out_tlast != want.last ||
            out_tuser[3] != want.err) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp data %h kind %0d code %h end %b err %b",
                     want.data, want.kind, want.code, want.last, want.err);
            $display("          got data %h kind %0d code %h end %b err %b",
                     out_tdata[7:0], out_tuser[2:0], out_tdata[23:8], out_tlast, out_tuser[3]);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off in its own process
  initial begin
    int gap;
    wait (rst_n);
    forever begin
      gap = quiet ? 0 : $urandom_range(0, 5);
      while (gap > 0 || hold_out) begin
        out_tready <= 1'b0;
        @(posedge clk);
        if (gap > 0) gap--;
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    wait (bytes_taken >= 300);
    @(posedge clk);
    hold_out <= 1'b1;
    repeat (300) @(posedge clk);
    hold_out <= 1'b0;
  end

  initial begin
    dir_row_t dir_tab [0:N_DIR-1];
    int pick;
    int enc;
    logic [3:0] op;
    logic [63:0] len;

    dir_tab = '{
      // fin binary, two bytes unmasked: both byte extremes
      '{8'h82, 1'b0, deframe_res_t'('0)},
      '{8'h02, 1'b0, deframe_res_t'('0)},
      '{8'h00, 1'b1, deframe_res_t'{8'h00, KIND_MSG, 16'h0000, 1'b0, 1'b0}},
      '{8'hFF, 1'b1, deframe_res_t'{8'hFF, KIND_MSG, 16'h0000, 1'b1, 1'b0}},
      // empty fin text frame
      '{8'h81, 1'b0, deframe_res_t'('0)},
      '{8'h00, 1'b1, deframe_res_t'{8'h00, KIND_END, 16'h0000, 1'b1, 1'b0}},
      // masked ping, RSV bits all set
      '{8'hF9, 1'b0, deframe_res_t'('0)},
      '{8'h81, 1'b0, deframe_res_t'('0)},
      '{8'h12, 1'b0, deframe_res_t'('0)},
      '{8'h34, 1'b0, deframe_res_t'('0)},
      '{8'h56, 1'b0, deframe_res_t'('0)},
      '{8'h78, 1'b0, deframe_res_t'('0)},
      '{8'hA5, 1'b0, deframe_res_t'('0)},
      // pong payload is swallowed
      '{8'h8A, 1'b0, deframe_res_t'('0)},
      '{8'h01, 1'b0, deframe_res_t'('0)},
      '{8'hAB, 1'b0, deframe_res_t'('0)},
      // fin continuation with 64-bit length of one
      '{8'h80, 1'b0, deframe_res_t'('0)},
      '{8'h7F, 1'b0, deframe_res_t'('0)},
      '{8'h00, 1'b0, deframe_res_t'('0)},
      '{8'h00, 1'b0, deframe_res_t'('0)},
      '{8'h00, 1'b0, deframe_res_t'('0)},
      '{8'h00, 1'b0, deframe_res_t'('0)},
      '{8'h00, 1'b0, deframe_res_t'('0)},
      '{8'h00, 1'b0, deframe_res_t'('0)},
      '{8'h00, 1'b0, deframe_res_t'('0)},
      '{8'h01, 1'b0, deframe_res_t'('0)},
      '{8'h3C, 1'b1, deframe_res_t'{8'h3C, KIND_MSG, 16'h0000, 1'b1, 1'b0}}
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++)
      send_byte(dir_tab[i].rx, dir_tab[i].typed, dir_tab[i].res);
    frames_sent += 5;

    while (bytes_taken < 750) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) op = 4'($urandom_range(0, 2));
      else if (pick < 75) op = OP_PING;
      else if (pick < 85) op = OP_PONG;
      else op = $urandom_range(0, 1) ? 4'($urandom_range(3, 7)) : 4'($urandom_range(11, 15));
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        enc = 0;
        len = 64'($urandom_range(0, 20));
      end else if (pick == 6) begin
        enc = 0;
        len = 64'($urandom_range(0, 125));
      end else if (pick < 9) begin
        enc = 1;
        len = 64'($urandom_range(0, ($urandom_range(0, 9) == 0) ? 300 : 40));
      end else begin
        enc = 2;
        len = 64'($urandom_range(0, 40));
      end
      send_frame(op, 1'($urandom), len, 1'($urandom), enc);
    end

    // the link closes exactly once per run; the seed picks how
    pick = $urandom_range(0, 4);
    case (pick)
      0: begin
        end_how = "close with code and reason";
        send_frame(OP_CLOSE, 1'b1, 64'($urandom_range(3, 8)), 1'($urandom), 0);
      end
      1: begin
        end_how = "empty close";
        send_frame(OP_CLOSE, 1'b1, 64'd0, 1'($urandom), 0);
      end
      2: begin
        end_how = "one-byte close";
        send_frame(OP_CLOSE, 1'b1, 64'd1, 1'($urandom), 0);
      end
      3: begin
        end_how = "close with code only";
        send_frame(OP_CLOSE, 1'b1, 64'd2, 1'($urandom), 0);
      end
      default: begin
        end_how = "oversized length";
        len = $urandom_range(0, 1) ? 64'h0000_0001_0000_0000
                                   : ({$urandom, $urandom} | 64'h0000_0001_0000_0000);
        send_frame(4'($urandom_range(0, 2)), 1'b1, len, 1'($urandom), 2);
      end
    endcase
    // bytes after the close are taken and dropped
    repeat (12) send_byte(8'($urandom), 1'b0, '0);
    in_tvalid <= 1'b0;

    while (due_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("deframer run: %0d bytes over %0d frames, %0d results checked, %0d mismatches",
             bytes_taken, frames_sent, results_seen, mismatches);
    $display("data, ping, pong and unknown opcodes, 7/16/64-bit lengths; link ended by %s",
             end_how);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
